[hdl/revisit_window_check_macros.svh]
// Assertion macros used by the checker file rwc_checker.sv.
`ifndef REVISIT_WINDOW_CHECK_MACROS_SVH
`define REVISIT_WINDOW_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("revisit_window_check: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("revisit_window_check: next-cycle check failed");

`endif

[hdl/rwc_pkg.sv]
`timescale 1ns / 1ps

package rwc_pkg;

  localparam logic CMD_LOG   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_MARGIN = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  localparam int CFG_DW = 31;
  localparam int WIN_W  = 11;

  localparam logic [30:0] MARGIN_RESET = 31'd65536;
  localparam logic [10:0] WINDOW_RESET = 11'd600;

  typedef struct packed {
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic signed [31:0] goal_fwd;
    logic signed [31:0] goal_side;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
  } out_item_t;

  // Quarter-wave sine in Q1.14 at steps of 1024 heading units; entries past
  // the end of the quarter read as full scale.
  function automatic logic [14:0] sine_tbl(input logic [4:0] i);
    logic [14:0] v;
    case (i)
      5'd0:    v = 15'd0;
      5'd1:    v = 15'd1606;
      5'd2:    v = 15'd3196;
      5'd3:    v = 15'd4756;
      5'd4:    v = 15'd6270;
      5'd5:    v = 15'd7723;
      5'd6:    v = 15'd9102;
      5'd7:    v = 15'd10394;
      5'd8:    v = 15'd11585;
      5'd9:    v = 15'd12665;
      5'd10:   v = 15'd13623;
      5'd11:   v = 15'd14449;
      5'd12:   v = 15'd15137;
      5'd13:   v = 15'd15679;
      5'd14:   v = 15'd16069;
      5'd15:   v = 15'd16305;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

endpackage

[hdl/revisit_window_check.sv]
// A log item is taken and gives no result; start may follow at once. A query scans
// the newest n logged positions, n = min(window_len, positions held, which saturate
// at LOG_DEPTH); a match ends the scan early. The next item can be taken during the
// result cycle. Synchronous active-low reset clears pointer, fill count, config and
// control; the history memory is not cleared. The result strobe lasts one cycle; no
// backpressure.
`timescale 1ns / 1ps

module revisit_window_check #(
  parameter int LOG_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  rwc_pkg::in_item_t         in_item,
  output logic                      out_valid,
  output rwc_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rwc_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int FW = AW + 1;
  localparam int CW = (FW > rwc_pkg::WIN_W) ? FW : rwc_pkg::WIN_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(LOG_DEPTH - 1);
  localparam logic [FW-1:0] FULL_CNT  = FW'(LOG_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SMUL  = 4'd1;
  localparam logic [3:0] S_SFIN  = 4'd2;
  localparam logic [3:0] S_CMUL  = 4'd3;
  localparam logic [3:0] S_CFIN  = 4'd4;
  localparam logic [3:0] S_M0    = 4'd5;
  localparam logic [3:0] S_M1    = 4'd6;
  localparam logic [3:0] S_M2    = 4'd7;
  localparam logic [3:0] S_M3    = 4'd8;
  localparam logic [3:0] S_M4    = 4'd9;
  localparam logic [3:0] S_M5    = 4'd10;
  localparam logic [3:0] S_M6    = 4'd11;
  localparam logic [3:0] S_BOUND = 4'd12;
  localparam logic [3:0] S_SCAN  = 4'd13;

  logic [3:0] state_r, state_nxt;

  logic [30:0] margin_r;
  logic [10:0] window_r;

  logic [AW-1:0] wptr_r;
  logic [FW-1:0] fill_r;

  logic signed [31:0] hist_x [LOG_DEPTH];
  logic signed [31:0] hist_y [LOG_DEPTH];
  logic signed [31:0] hx_q_r, hy_q_r;
  logic               qv_r;
  logic [AW-1:0]      rd_addr_r;
  logic [CW-1:0]      rem_r;
  logic               rd_en;

  rwc_pkg::in_item_t  item_r;
  logic signed [15:0] sin_r, cos_r;
  logic [14:0]        base_r;
  logic               neg_r;
  logic signed [47:0] prod_r;
  logic signed [47:0] acc_r;
  logic [33:0]        rot_r;
  logic signed [31:0] wx_r, wy_r;
  logic signed [33:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic               found_r;
  logic               out_valid_r;

  logic        accept;
  logic        log_acc;

  // Sine interpolation front end.
  logic [15:0] ang;
  logic [14:0] aq;
  logic [4:0]  tidx;
  logic [14:0] tbase, tdiff;
  logic [20:0] interp_sum;
  logic [15:0] mag;
  logic signed [15:0] trig_val;

  // Shared multiplier.
  logic signed [15:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [47:0] mul_p;

  // Rotation output path.
  logic signed [47:0] rnd_sum;
  logic signed [31:0] pos_sel;
  logic signed [34:0] wsum;
  logic signed [31:0] wsat;

  // Scan compare.
  logic signed [33:0] hx_ext, hy_ext;
  logic               hit;
  logic [CW-1:0]      win_ext, fill_ext, scan_n;

  assign accept  = start && (state_r == S_IDLE);
  assign log_acc = accept && (in_item.command == rwc_pkg::CMD_LOG);
  assign busy    = (state_r != S_IDLE);
  assign rd_en   = (state_r == S_SCAN) && (rem_r != '0);

  always_comb begin
    ang  = (state_r == S_CMUL) ? 16'(item_r.heading + 16'd16384) : item_r.heading;
    aq   = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    tidx = aq[14:10];
    tbase = rwc_pkg::sine_tbl(tidx);
    tdiff = 15'(rwc_pkg::sine_tbl(5'(tidx + 5'd1)) - tbase);
    interp_sum = 21'(prod_r[20:0] + 21'd512);
    mag = 16'(base_r) + {5'd0, interp_sum[20:10]};
    trig_val = neg_r ? -$signed(mag) : $signed(mag);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r) inside
      S_SMUL, S_CMUL: begin
        mul_a = $signed({1'b0, tdiff});
        mul_b = $signed({22'd0, aq[9:0]});
      end
      S_M0: begin
        mul_a = cos_r;
        mul_b = item_r.goal_fwd;
      end
      S_M1: begin
        mul_a = sin_r;
        mul_b = item_r.goal_side;
      end
      S_M2: begin
        mul_a = cos_r;
        mul_b = item_r.goal_side;
      end
      S_M3: begin
        mul_a = sin_r;
        mul_b = item_r.goal_fwd;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    rnd_sum = acc_r + 48'sd8192;
    pos_sel = (state_r == S_M4) ? item_r.pos_x : item_r.pos_y;
    wsum    = 35'(pos_sel) + $signed({rot_r[33], rot_r});
    if (wsum[34:31] == 4'b0000 || wsum[34:31] == 4'b1111) begin
      wsat = wsum[31:0];
    end else if (wsum[34]) begin
      wsat = 32'sh8000_0000;
    end else begin
      wsat = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    hx_ext = 34'(hx_q_r);
    hy_ext = 34'(hy_q_r);
    hit = qv_r && (hx_ext >= xlo_r) && (hx_ext <= xhi_r)
               && (hy_ext >= ylo_r) && (hy_ext <= yhi_r);
    win_ext  = CW'(window_r);
    fill_ext = CW'(fill_r);
    scan_n   = (win_ext < fill_ext) ? win_ext : fill_ext;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_item.command == rwc_pkg::CMD_QUERY) begin
          state_nxt = S_SMUL;
        end
      end
      S_SMUL:  state_nxt = S_SFIN;
      S_SFIN:  state_nxt = S_CMUL;
      S_CMUL:  state_nxt = S_CFIN;
      S_CFIN:  state_nxt = S_M0;
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_M5;
      S_M5:    state_nxt = S_M6;
      S_M6:    state_nxt = S_BOUND;
      S_BOUND: state_nxt = S_SCAN;
      S_SCAN: begin
        if (hit || (rem_r == '0 && !qv_r)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      margin_r    <= rwc_pkg::MARGIN_RESET;
      window_r    <= rwc_pkg::WINDOW_RESET;
      wptr_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      qv_r        <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_SCAN) && (state_nxt == S_IDLE);
      qv_r        <= rd_en;
      if (cfg_we) begin
        if (cfg_index == rwc_pkg::REG_MARGIN) begin
          margin_r <= cfg_wdata;
        end else begin
          window_r <= cfg_wdata[10:0];
        end
      end
      if (log_acc) begin
        wptr_r <= (wptr_r == LAST_ADDR) ? '0 : AW'(wptr_r + 1'b1);
        if (fill_r != FULL_CNT) begin
          fill_r <= FW'(fill_r + 1'b1);
        end
      end
      if (state_r == S_BOUND) begin
        rem_r <= scan_n;
      end else if (rd_en) begin
        rem_r <= CW'(rem_r - 1'b1);
      end
    end
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (log_acc) begin
      hist_x[wptr_r] <= in_item.pos_x;
      hist_y[wptr_r] <= in_item.pos_y;
    end
    if (rd_en) begin
      hx_q_r <= hist_x[rd_addr_r];
      hy_q_r <= hist_y[rd_addr_r];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    unique case (state_r) inside
      S_SMUL, S_CMUL: begin
        prod_r <= mul_p;
        base_r <= tbase;
        neg_r  <= ang[15];
      end
      S_SFIN: sin_r <= trig_val;
      S_CFIN: cos_r <= trig_val;
      S_M0: prod_r <= mul_p;
      S_M1: begin
        acc_r  <= prod_r;
        prod_r <= mul_p;
      end
      S_M2: begin
        acc_r  <= acc_r - prod_r;
        prod_r <= mul_p;
      end
      S_M3: begin
        rot_r  <= rnd_sum[47:14];
        acc_r  <= prod_r;
        prod_r <= mul_p;
      end
      S_M4: begin
        wx_r  <= wsat;
        acc_r <= acc_r + prod_r;
      end
      S_M5: rot_r <= rnd_sum[47:14];
      S_M6: wy_r  <= wsat;
      S_BOUND: begin
        xlo_r     <= 34'(wx_r) - $signed({3'd0, margin_r});
        xhi_r     <= 34'(wx_r) + $signed({3'd0, margin_r});
        ylo_r     <= 34'(wy_r) - $signed({3'd0, margin_r});
        yhi_r     <= 34'(wy_r) + $signed({3'd0, margin_r});
        rd_addr_r <= (wptr_r == '0) ? LAST_ADDR : AW'(wptr_r - 1'b1);
        found_r   <= 1'b0;
      end
      S_SCAN: begin
        if (rd_en) begin
          rd_addr_r <= (rd_addr_r == '0) ? LAST_ADDR : AW'(rd_addr_r - 1'b1);
        end
        if (hit) begin
          found_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_item.found   = found_r;
  assign out_item.world_x = wx_r;
  assign out_item.world_y = wy_r;

endmodule

[hdl/rwc_checker.sv]
`timescale 1ns / 1ps
`include "revisit_window_check_macros.svh"

module rwc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input rwc_pkg::in_item_t         in_item,
  input logic                      out_valid,
  input rwc_pkg::out_item_t        out_item
);

  logic log_take, query_take;

  assign log_take   = start && !busy && (in_item.command == rwc_pkg::CMD_LOG);
  assign query_take = start && !busy && (in_item.command == rwc_pkg::CMD_QUERY);

  // A result appears only once the block has returned to idle.
  `RWC_ASSERT_SAME(a_result_when_idle, out_valid, !busy)
  // Each query gives exactly one strobe, never two in a row.
  `RWC_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  // A logged item leaves the block free and gives no result.
  `RWC_ASSERT_NEXT(a_log_no_result, log_take, !busy && !out_valid)
  // A query keeps the block busy while it works.
  `RWC_ASSERT_NEXT(a_query_busy, query_take, busy && !out_valid)

endmodule

bind revisit_window_check rwc_checker u_rwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

[tb/revisit_checker.sv]
`timescale 1ns / 1ps

module revisit_checker #(
  parameter int HIST_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  rwc_pkg::in_item_t             in_item,
  input  logic                          out_valid,
  input  rwc_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rwc_pkg::CFG_DW-1:0]    cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import rwc_pkg::*;

  localparam int SLOT_W = $clog2(HIST_DEPTH);

  localparam int unsigned QUARTER_WAVE [17] = '{
    0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
    12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384
  };

  logic signed [31:0] seen_x [HIST_DEPTH];
  logic signed [31:0] seen_y [HIST_DEPTH];
  int unsigned        next_slot;
  int unsigned        stored;
  logic [30:0]        box_half;
  logic [WIN_W-1:0]   search_len;
  out_item_t          answers_q [$];

  // First-quadrant sine, linear interpolation between table points, rounded half up.
  function automatic longint quarter_sine(input int unsigned a);
    int unsigned seg;
    int unsigned frac;
    seg  = a >> 10;
    frac = a & 1023;
    if (seg >= 16) return 16384;
    return longint'(QUARTER_WAVE[5'(seg)] +
                    (((QUARTER_WAVE[5'(seg + 1)] - QUARTER_WAVE[5'(seg)]) * frac + 512)
                     >> 10));
  endfunction

  function automatic longint sine_q14(input logic [15:0] h);
    int unsigned a;
    a = 32'(h[13:0]);
    case (h[15:14])
      2'd0:    return quarter_sine(a);
      2'd1:    return quarter_sine(16384 - a);
      2'd2:    return -quarter_sine(a);
      default: return -quarter_sine(16384 - a);
    endcase
  endfunction

  function automatic longint round_q14(input longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic out_item_t predict_query(input in_item_t q);
    out_item_t   res;
    logic [15:0] cos_angle;
    longint      c, s, gf, gs, wx, wy, m, hx, hy;
    int unsigned n, idx;
    bit          hit;
    cos_angle = q.heading + 16'h4000;
    s  = sine_q14(q.heading);
    c  = sine_q14(cos_angle);
    gf = longint'($signed(q.goal_fwd));
    gs = longint'($signed(q.goal_side));
    wx = clamp_s32(longint'($signed(q.pos_x)) + round_q14(c * gf - s * gs));
    wy = clamp_s32(longint'($signed(q.pos_y)) + round_q14(c * gs + s * gf));
    m  = longint'(box_half);
    n  = (32'(search_len) < stored) ? 32'(search_len) : stored;
    hit = 1'b0;
    // Newest entry first; the box is built around the saturated world point.
    for (int unsigned k = 0; k < n && !hit; k++) begin
      idx = (next_slot + HIST_DEPTH - 1 - k) % HIST_DEPTH;
      hx  = longint'(seen_x[SLOT_W'(idx)]);
      hy  = longint'(seen_y[SLOT_W'(idx)]);
      if (hx >= wx - m && hx <= wx + m && hy >= wy - m && hy <= wy + m) hit = 1'b1;
    end
    res.found   = hit;
    res.world_x = wx[31:0];
    res.world_y = wy[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      next_slot  = 0;
      stored     = 0;
      box_half   = MARGIN_RESET;
      search_len = WINDOW_RESET;
      answers_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (answers_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no query waiting, expected none, actual %h",
                   $time, out_item);
        end else begin
          want = answers_q.pop_front();
          if (out_item.found !== want.found) begin
            fail_count++;
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, want.found, out_item.found);
          end
          if (out_item.world_x !== want.world_x) begin
            fail_count++;
            $display("%0t: world_x mismatch, expected %0d, actual %0d",
                     $time, want.world_x, out_item.world_x);
          end
          if (out_item.world_y !== want.world_y) begin
            fail_count++;
            $display("%0t: world_y mismatch, expected %0d, actual %0d",
                     $time, want.world_y, out_item.world_y);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MARGIN) box_half = cfg_wdata;
        else if (cfg_index == REG_WINDOW) search_len = cfg_wdata[WIN_W-1:0];
      end
      if (start && !busy) begin
        if (in_item.command == CMD_QUERY) begin
          answers_q.push_back(predict_query(in_item));
        end else begin
          seen_x[SLOT_W'(next_slot)] = in_item.pos_x;
          seen_y[SLOT_W'(next_slot)] = in_item.pos_y;
          next_slot = (next_slot + 1) % HIST_DEPTH;
          if (stored < HIST_DEPTH) stored++;
        end
      end
    end
    pending = answers_q.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import rwc_pkg::*;

  localparam int     HIST_DEPTH    = 1024;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     STALL_LIMIT   = 20000;
  localparam longint S32_MAX       = 64'sd2147483647;
  localparam longint S32_MIN       = -64'sd2147483648;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_item;
  logic               out_valid;
  out_item_t          out_item;
  logic               cfg_we;
  logic               cfg_index;
  logic [CFG_DW-1:0]  cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 stall_cycles = 0;
  int unsigned        cur_margin;
  int unsigned        cur_window;
  logic signed [31:0] logged_x [$];
  logic signed [31:0] logged_y [$];

  always #5 clk = ~clk;

  revisit_window_check #(
    .LOG_DEPTH (HIST_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  revisit_checker #(
    .HIST_DEPTH (HIST_DEPTH)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Ends the run if neither an item nor a result moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic in_item_t mk(input logic cmd, input longint px, input longint py,
                                  input int unsigned h, input longint gf, input longint gs);
    in_item_t it;
    it.command   = cmd;
    it.pos_x     = px[31:0];
    it.pos_y     = py[31:0];
    it.heading   = h[15:0];
    it.goal_fwd  = gf[31:0];
    it.goal_side = gs[31:0];
    return it;
  endfunction

  // Uniform in [-half, half]; half stays at or below 2^30.
  function automatic longint rand_span(input longint half);
    return longint'($urandom_range(0, 32'(2 * half))) - half;
  endfunction

  // Offsets that put a logged point at the centre, on the box edge, just outside it or anywhere inside.
  function automatic longint edge_offset(input longint m);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return m;
      2:       return -m;
      3:       return m + 1;
      4:       return -(m + 1);
      default: return rand_span((m > 64'sd1073741824) ? 64'sd1073741824 : m);
    endcase
  endfunction

  function automatic in_item_t make_log();
    int     mode;
    longint px, py;
    mode = $urandom_range(0, 99);
    if (mode < 40) begin
      px = rand_span(64'sd1 << 20);
      py = rand_span(64'sd1 << 20);
    end else if (mode < 80 && logged_x.size() > 0) begin
      px = longint'(logged_x[$]) + rand_span(64'sd1 << 17);
      py = longint'(logged_y[$]) + rand_span(64'sd1 << 17);
    end else begin
      px = longint'($signed($urandom()));
      py = longint'($signed($urandom()));
    end
    return mk(CMD_LOG, px, py, $urandom(), longint'($signed($urandom())),
              longint'($signed($urandom())));
  endfunction

  // Most queries aim at a recent logged point so that matches are common.
  function automatic in_item_t make_query();
    int          mode;
    int unsigned lim, k;
    longint      tx, ty, wx, wy, gf, gs, rx, ry, m, half;
    logic [15:0] h;
    mode = $urandom_range(0, 99);
    m    = longint'(cur_margin);
    if (logged_x.size() == 0 || mode >= 70)
      return mk(CMD_QUERY, longint'($signed($urandom())), longint'($signed($urandom())),
                $urandom(), longint'($signed($urandom())), longint'($signed($urandom())));
    lim = logged_x.size();
    if (lim > cur_window + 2) lim = cur_window + 2;
    if (lim > 40) lim = 40;
    k  = $urandom_range(0, lim - 1);
    tx = longint'(logged_x[logged_x.size() - 1 - k]);
    ty = longint'(logged_y[logged_y.size() - 1 - k]);
    if (mode < 35) begin
      // Quarter-turn headings rotate exactly, so the world point is known here.
      wx = tx - edge_offset(m);
      wy = ty - edge_offset(m);
      gf = rand_span(64'sd1 << 18);
      gs = rand_span(64'sd1 << 18);
      h  = {2'($urandom_range(0, 3)), 14'd0};
      case (h[15:14])
        2'd0:    begin rx = gf;  ry = gs;  end
        2'd1:    begin rx = -gs; ry = gf;  end
        2'd2:    begin rx = -gf; ry = -gs; end
        default: begin rx = gs;  ry = -gf; end
      endcase
      return mk(CMD_QUERY, wx - rx, wy - ry, 32'(h), gf, gs);
    end
    half = (m / 2 > 64'sd1073741824) ? 64'sd1073741824 : m / 2;
    gf   = (m / 4 > 64'sd268435456) ? 64'sd268435456 : m / 4;
    return mk(CMD_QUERY, tx + rand_span(half), ty + rand_span(half), $urandom(),
              rand_span(gf), rand_span(gf));
  endfunction

  // Called and returning at a falling edge.
  task automatic send(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (it.command == CMD_LOG) begin
      logged_x.push_back(it.pos_x);
      logged_y.push_back(it.pos_y);
      if (logged_x.size() > 2100) begin
        void'(logged_x.pop_front());
        void'(logged_y.pop_front());
      end
    end
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every query has answered and the block has gone quiet.
  task automatic settle();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned margin_val, input int unsigned window_val,
                           input int n_items, input int log_pct, input int burst,
                           input bit steady);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MARGIN;
    cfg_wdata <= CFG_DW'(margin_val);
    @(negedge clk);
    // Bits above the window field are junk that the block must ignore.
    cfg_index <= REG_WINDOW;
    cfg_wdata <= CFG_DW'(($urandom() & ~32'h7FF) | window_val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_margin = margin_val;
    cur_window = window_val;
    repeat (burst) send(make_log());
    for (int i = 0; i < n_items; i++) begin
      if (!steady) begin
        while ($urandom_range(0, 99) < 18) idle_cycle();
        if ($urandom_range(0, 99) == 0) settle();
      end
      if ($urandom_range(0, 99) < log_pct) send(make_log());
      else send(make_query());
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MARGIN;
    cfg_wdata <= '0;
    cur_margin = 32'(MARGIN_RESET);
    cur_window = 32'(WINDOW_RESET);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items under the reset settings.
    send(mk(CMD_QUERY, 0, 0, 0, 0, 0));
    send(mk(CMD_LOG, 0, 0, 16'hFFFF, -1, -1));
    send(mk(CMD_LOG, S32_MAX, S32_MAX, 0, 0, 0));
    send(mk(CMD_LOG, S32_MIN, S32_MIN, 0, 0, 0));
    send(mk(CMD_LOG, 1000000, 1000000, 0, 0, 0));
    send(mk(CMD_QUERY, 0, 0, 0, 0, 0));
    send(mk(CMD_QUERY, S32_MAX, S32_MAX, 0, S32_MAX, S32_MAX));
    send(mk(CMD_QUERY, S32_MIN, S32_MIN, 0, S32_MIN, S32_MIN));
    // Inclusive edge of the box, then one unit beyond it.
    send(mk(CMD_QUERY, 1000000 + 65536, 1000000 - 65536, 0, 0, 0));
    send(mk(CMD_QUERY, 1000000 + 65537, 1000000, 0, 0, 0));
    send(mk(CMD_QUERY, 0, 0, 16'h4000, 64'sd1 << 20, 3 << 16));
    send(mk(CMD_QUERY, 0, 0, 16'h8000, 5 << 16, -(7 << 16)));
    send(mk(CMD_QUERY, 0, 0, 16'hC000, -(9 << 16), 2 << 16));
    send(mk(CMD_QUERY, 0, 0, 16'hFFFF, -1, -1));
    send(mk(CMD_QUERY, 0, 0, 16'h2000, S32_MAX, S32_MIN));
    send(mk(CMD_QUERY, 5 << 16, -(7 << 16), 16'h03FF, 12345678, -9876543));
    send(mk(CMD_QUERY, S32_MIN, S32_MAX, 16'h7FFF, S32_MIN, S32_MAX));
    send(mk(CMD_QUERY, -1, -1, 16'hFFFF, -1, -1));

    // The long log burst of 980 items fills most of the 1024-entry history ring before the wide-window phases.
    run_phase(0, 1, 20, 55, 0, 1'b0);
    run_phase(1, 0, 20, 55, 0, 1'b0);
    run_phase(65536, 16, 20, 70, 980, 1'b1);
    run_phase($urandom_range(1 << 10, 1 << 24), 64, 20, 60, 0, 1'b0);
    run_phase(32'h7FFF_FFFF, 8, 20, 55, 0, 1'b0);
    run_phase(65536, 2047, 20, 65, 0, 1'b0);
    run_phase(1 << 20, 1024, 20, 65, 0, 1'b0);
    run_phase(32'(MARGIN_RESET), 32'(WINDOW_RESET), 20, 60, 0, 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/rwc_pkg.sv
hdl/revisit_window_check.sv
hdl/rwc_checker.sv
tb/revisit_checker.sv
tb/tb_top.sv
